@@ rtl/lhp_pkg.sv @@
package lhp_pkg;

   // Default histogram size
   localparam int NUM_BUCKETS_DEF = 1024;

   // Field widths of the transactions
   localparam int BUCKET_W = 10;
   localparam int NS_W     = 40;
   localparam int PPM_W    = 20;
   localparam int CNT_W    = 32;
   localparam int SUM_W    = 64;

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_PAD_W  = RSP_DATA_W - BUCKET_W - CNT_W - SUM_W;

   // Nanosecond to microsecond rounding: ceil(ns / 1000) through a reciprocal.
   // The reciprocal ceil(2^41 / 1000) is exact for every dividend below 2^31.
   localparam int                    NS_PER_US      = 1000;
   localparam int                    NS_ROUND_UP    = 999;
   localparam int                    US_X_W         = NS_W + 1;
   localparam int                    US_MUL_W       = 31;
   localparam int                    US_RECIP_W     = 32;
   localparam int                    US_PROD_W      = US_MUL_W + US_RECIP_W;
   localparam int                    US_RECIP_SHIFT = 41;
   localparam logic [US_RECIP_W-1:0] US_RECIP       = 32'd2199023256;

   // Percentile target: ceil(count * ppm / 1000000)
   localparam int QPROD_W      = CNT_W + PPM_W;
   localparam int DVD_W        = QPROD_W + 1;
   localparam int DIVISOR_W    = 20;
   localparam int TGT_W        = 34;
   localparam int PPM_SCALE    = 1000000;
   localparam int PPM_ROUND_UP = 999999;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_REC_MUL,
      ST_REC_IDX,
      ST_REC_READ,
      ST_REC_WRITE,
      ST_QRY_DSTART,
      ST_QRY_DIV,
      ST_QRY_WINIT,
      ST_QRY_WALK,
      ST_QRY_DONE
   } lhp_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic load;
      logic rec_mul;
      logic rec_idx;
      logic rec_commit;
      logic div_start;
      logic walk_init;
      logic walk_run;
      logic zero_answer;
      logic qry_commit;
   } lhp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic is_query;
      logic count_zero;
      logic div_done;
      logic walk_done;
      logic out_free;
   } lhp_status_type;

   // Saturating increment of a counter
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
      logic [CNT_W-1:0] result;
      result = (value == CNT_MAX) ? value : value + CNT_W'(1);
      return result;
   endfunction

endpackage

@@ rtl/lhp_div.sv @@
module lhp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lhp_pkg::DVD_W-1:0]   dividend,
   output logic                        done,
   output logic [lhp_pkg::DVD_W-1:0]   quotient
);
   import lhp_pkg::*;

   // Division by 1000000 as a shift right by 6 followed by a reciprocal multiply by 1/15625.
   // The reciprocal floor(2^45 / 15625) undershoots by less than three for any shifted
   // dividend below 2^47, so a remainder check of at most three steps finishes the quotient.
   localparam int                 PRE_SHIFT   = 6;
   localparam int                 ODD_DIV     = PPM_SCALE >> PRE_SHIFT;
   localparam int                 E_W         = DVD_W - PRE_SHIFT;
   localparam int                 E_LO_W      = 24;
   localparam int                 E_HI_W      = E_W - E_LO_W;
   localparam int                 RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP       = 32'd2251799813;
   localparam int                 RECIP_SHIFT = 45;
   localparam int                 P_LO_W      = E_LO_W + RECIP_W;
   localparam int                 P_HI_W      = E_HI_W + RECIP_W;
   localparam int                 P_W         = E_W + RECIP_W;
   localparam int                 Q_W         = P_W - RECIP_SHIFT;
   localparam int                 R_W         = 17;
   localparam int                 ODD_W       = 14;
   localparam int                 QK_W        = R_W + ODD_W;
   localparam logic [ODD_W-1:0]   ODD_K       = ODD_W'(ODD_DIV);
   localparam logic [R_W-1:0]     ODD_X1      = R_W'(ODD_DIV);
   localparam logic [R_W-1:0]     ODD_X2      = R_W'(2 * ODD_DIV);
   localparam logic [R_W-1:0]     ODD_X3      = R_W'(3 * ODD_DIV);

   logic                 p_valid_ff;
   logic                 q_valid_ff;
   logic                 r_valid_ff;
   logic                 done_ff;
   logic [P_LO_W-1:0]    p_lo_ff;
   logic [P_HI_W-1:0]    p_hi_ff;
   logic [R_W-1:0]       e_lo_ff;
   logic [Q_W-1:0]       q0_ff;
   logic [R_W-1:0]       rem_ff;
   logic [Q_W-1:0]       quo_ff;

   logic [E_W-1:0]       e_val;
   logic [P_W-1:0]       p_sum;
   logic [QK_W-1:0]      q0_prod;
   logic [1:0]           fix;

   // Shifted dividend, the combined partial products and the low bits of the estimate
   // times 15625; the remainder is small, so its low bits are enough.
   assign e_val   = dividend[DVD_W-1:PRE_SHIFT];
   assign p_sum   = (P_W'(p_hi_ff) << E_LO_W) + P_W'(p_lo_ff);
   assign q0_prod = QK_W'(q0_ff[R_W-1:0]) * QK_W'(ODD_K);

   // Correction of the estimate from the remainder.
   always_comb begin
      if (rem_ff >= ODD_X3) begin
         fix = 2'd3;
      end else if (rem_ff >= ODD_X2) begin
         fix = 2'd2;
      end else if (rem_ff >= ODD_X1) begin
         fix = 2'd1;
      end else begin
         fix = 2'd0;
      end
   end

   // Stage valid bits: partial products, estimate, remainder, quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         p_valid_ff <= start;
         q_valid_ff <= p_valid_ff;
         r_valid_ff <= q_valid_ff;
         done_ff    <= r_valid_ff;
      end
   end

   // Datapath of the four stages.
   always_ff @(posedge clock) begin
      if (start) begin
         p_lo_ff <= P_LO_W'(e_val[E_LO_W-1:0]) * P_LO_W'(RECIP);
         p_hi_ff <= P_HI_W'(e_val[E_W-1:E_LO_W]) * P_HI_W'(RECIP);
         e_lo_ff <= e_val[R_W-1:0];
      end
      if (p_valid_ff) begin
         q0_ff <= p_sum[P_W-1:RECIP_SHIFT];
      end
      if (q_valid_ff) begin
         rem_ff <= e_lo_ff - q0_prod[R_W-1:0];
      end
      if (r_valid_ff) begin
         quo_ff <= q0_ff + Q_W'(fix);
      end
   end

   assign done     = done_ff;
   assign quotient = DVD_W'(quo_ff);

endmodule

@@ rtl/lhp_datapath.sv @@
module lhp_datapath #(
   parameter int NUM_BUCKETS = lhp_pkg::NUM_BUCKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lhp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   output logic [lhp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  lhp_pkg::lhp_cmd_type              cmd,
   output lhp_pkg::lhp_status_type           status
);
   import lhp_pkg::*;

   localparam int                IDX_W       = $clog2(NUM_BUCKETS);
   localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(NUM_BUCKETS - 1);
   localparam logic [US_X_W-1:0] CLAMP_LIMIT = US_X_W'(NS_PER_US * (NUM_BUCKETS - 1));
   localparam int                RUN_W       = CNT_W + IDX_W;
   localparam int                CMP_W       = (RUN_W > TGT_W) ? RUN_W : TGT_W;

   // Captured transaction
   logic               query_ff;
   logic [NS_W-1:0]    ns_ff;
   logic [PPM_W-1:0]   ppm_ff;

   // Record path
   logic [US_X_W-1:0]     x_in;
   logic [US_X_W-1:0]     x_ff;
   logic                  clamp_ff;
   logic [US_PROD_W-1:0]  us_prod_ff;
   logic [IDX_W-1:0]      idx_ff;

   // Totals
   logic [CNT_W-1:0]   samples_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   samples_in;
   logic [SUM_W-1:0]   sum_in;

   // Query path
   logic [QPROD_W-1:0] qprod_ff;
   logic [DVD_W-1:0]   dividend;
   logic [DVD_W-1:0]   quotient;
   logic               div_done;
   logic [TGT_W-1:0]   target_ff;

   // Bucket counter memory
   logic [CNT_W-1:0]   bucket_mem [NUM_BUCKETS];
   logic [IDX_W-1:0]   rd_addr;
   logic [CNT_W-1:0]   rd_data_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [CNT_W-1:0]   wr_data;
   logic [IDX_W-1:0]   clr_ptr_ff;

   // Bucket walk
   logic [IDX_W-1:0]   issue_ptr_ff;
   logic               issue_end_ff;
   logic               issue;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [RUN_W-1:0]   running_ff;
   logic [RUN_W-1:0]   run_sum;
   logic               hit;
   logic               found_ff;
   logic [IDX_W-1:0]   answer_ff;

   // Result register
   logic                  rsp_valid_ff;
   logic [BUCKET_W-1:0]   bucket_out_ff;
   logic [CNT_W-1:0]      count_out_ff;
   logic [SUM_W-1:0]      sum_out_ff;

   // Capture the accepted transaction.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         query_ff <= req_tuser;
         ns_ff    <= req_tdata[NS_W-1:0];
         ppm_ff   <= req_tdata[NS_W +: PPM_W];
      end
   end

   // Round up to microseconds: add the rounding term and check the clamp.
   assign x_in = US_X_W'(ns_ff) + US_X_W'(NS_ROUND_UP);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= x_in;
         clamp_ff <= x_in >= CLAMP_LIMIT;
         qprod_ff <= QPROD_W'(samples_ff) * QPROD_W'(ppm_ff);
      end
      if (cmd.rec_mul) begin
         us_prod_ff <= US_PROD_W'(x_ff[US_MUL_W-1:0]) * US_PROD_W'(US_RECIP);
      end
      if (cmd.rec_idx) begin
         idx_ff <= clamp_ff ? LAST_IDX : us_prod_ff[US_RECIP_SHIFT +: IDX_W];
      end
   end

   // Target division for a query.
   assign dividend = DVD_W'(qprod_ff) + DVD_W'(PPM_ROUND_UP);

   lhp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .done     (div_done),
      .quotient (quotient)
   );

   // A target of zero is raised to one.
   always_ff @(posedge clock) begin
      if (div_done) begin
         target_ff <= (quotient == '0) ? TGT_W'(1) : quotient[TGT_W-1:0];
      end
   end

   // Memory ports: the clearing pass or a record writes, the walk or a record reads.
   assign rd_addr = cmd.walk_run ? issue_ptr_ff : idx_ff;
   assign wr_en   = cmd.clear_step | cmd.rec_commit;
   assign wr_addr = cmd.clear_step ? clr_ptr_ff : idx_ff;
   assign wr_data = cmd.clear_step ? '0 : sat_inc(rd_data_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bucket_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= bucket_mem[rd_addr];
   end

   // Clearing pass pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
      end else if (cmd.clear_step && clr_ptr_ff != LAST_IDX) begin
         clr_ptr_ff <= clr_ptr_ff + IDX_W'(1);
      end
   end

   // Sample count and nanosecond sum.
   assign samples_in = sat_inc(samples_ff);
   assign sum_in     = sum_ff + SUM_W'(ns_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= '0;
         sum_ff     <= '0;
      end else if (cmd.rec_commit) begin
         samples_ff <= samples_in;
         sum_ff     <= sum_in;
      end
   end

   // Bucket walk: reads are issued one a cycle and accumulated from the registered read data.
   assign issue   = !issue_end_ff && !found_ff;
   assign run_sum = running_ff + RUN_W'(rd_data_ff);
   assign hit     = CMP_W'(run_sum) >= CMP_W'(target_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.walk_init) begin
         issue_ptr_ff <= '0;
         issue_end_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         running_ff   <= '0;
         found_ff     <= 1'b0;
         if (reset) begin
            answer_ff <= '0;
         end
      end else if (cmd.walk_run) begin
         rd_valid_ff <= issue;
         rd_idx_ff   <= issue_ptr_ff;
         if (issue) begin
            if (issue_ptr_ff == LAST_IDX) begin
               issue_end_ff <= 1'b1;
            end else begin
               issue_ptr_ff <= issue_ptr_ff + IDX_W'(1);
            end
         end
         // The last bucket answers when the target is never reached.
         if (rd_valid_ff && !found_ff) begin
            running_ff <= run_sum;
            if (hit || rd_idx_ff == LAST_IDX) begin
               found_ff  <= 1'b1;
               answer_ff <= rd_idx_ff;
            end
         end
      end else if (cmd.zero_answer) begin
         answer_ff <= '0;
      end
   end

   // Result register; it is loaded only when empty or being emptied.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rec_commit || cmd.qry_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rec_commit) begin
         bucket_out_ff <= BUCKET_W'(idx_ff);
         count_out_ff  <= samples_in;
         sum_out_ff    <= sum_in;
      end else if (cmd.qry_commit) begin
         bucket_out_ff <= BUCKET_W'(answer_ff);
         count_out_ff  <= samples_ff;
         sum_out_ff    <= sum_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, sum_out_ff, count_out_ff, bucket_out_ff};

   // Status towards the controller.
   always_comb begin
      status.clear_last = clr_ptr_ff == LAST_IDX;
      status.is_query   = query_ff;
      status.count_zero = samples_ff == '0;
      status.div_done   = div_done;
      status.walk_done  = found_ff;
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule

@@ rtl/lhp_ctrl.sv @@
module lhp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  lhp_pkg::lhp_status_type  status,
   output lhp_pkg::lhp_cmd_type     cmd
);
   import lhp_pkg::*;

   lhp_state_type state_ff;
   lhp_state_type state_in;

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (!status.is_query) begin
               state_in = ST_REC_MUL;
            end else if (status.count_zero) begin
               cmd.zero_answer = 1'b1;
               state_in        = ST_QRY_DONE;
            end else begin
               state_in = ST_QRY_DSTART;
            end
         end
         ST_REC_MUL: begin
            cmd.rec_mul = 1'b1;
            state_in    = ST_REC_IDX;
         end
         ST_REC_IDX: begin
            cmd.rec_idx = 1'b1;
            state_in    = ST_REC_READ;
         end
         ST_REC_READ: begin
            state_in = ST_REC_WRITE;
         end
         ST_REC_WRITE: begin
            if (status.out_free) begin
               cmd.rec_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_QRY_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_QRY_DIV;
         end
         ST_QRY_DIV: begin
            if (status.div_done) begin
               state_in = ST_QRY_WINIT;
            end
         end
         ST_QRY_WINIT: begin
            cmd.walk_init = 1'b1;
            state_in      = ST_QRY_WALK;
         end
         ST_QRY_WALK: begin
            cmd.walk_run = 1'b1;
            if (status.walk_done) begin
               state_in = ST_QRY_DONE;
            end
         end
         ST_QRY_DONE: begin
            if (status.out_free) begin
               cmd.qry_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/latency_histogram_percentile.sv @@
// Latency histogram with percentile query. A request transaction either records a latency
// sample (tuser low), which is rounded up to whole microseconds, clamped to the last bucket
// and counted, or asks for a percentile in parts per million (tuser high), which returns
// the first bucket whose running count reaches ceil(count * ppm / 1000000), at least one,
// or the last bucket if none does. Every request gives one response carrying the bucket,
// the saturating sample count and the wrapping nanosecond sum. After reset the bucket
// memory is swept clear, one entry a cycle, before the first request is taken. A record
// loads, runs the reciprocal multiply, forms the index and does the read-modify-write of
// the counter memory before the next acceptance. A query loads, does the target division
// by reciprocal multiplication, sets up the walk, walks the buckets in order, stopping early
// at the answering bucket, and passes the read pipeline and the response; a query on an
// empty histogram skips the division and the walk and answers bucket zero. A response
// waiting in the output register does not hold up the acceptance of the next request.
module latency_histogram_percentile #(
   parameter int NUM_BUCKETS = lhp_pkg::NUM_BUCKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request: tdata = delay_ns[39:0], percentile_ppm[59:40], zero fill
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lhp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser = command (0 record, 1 query)
   input  logic                              req_tuser,
   // Response: tdata = bucket_us[9:0], sample_count[41:10], ns_sum[105:42], zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lhp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import lhp_pkg::*;

   lhp_cmd_type    cmd;
   lhp_status_type status;

   lhp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lhp_datapath #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

@@ tb/latency_histogram_percentile_tb.sv @@
module latency_histogram_percentile_tb;
   import lhp_pkg::*;

   localparam int   BUCKETS       = NUM_BUCKETS_DEF;
   localparam logic CMD_RECORD    = 1'b0;
   localparam logic CMD_QUERY     = 1'b1;
   localparam int   RANDOM_ITEMS  = 1500;
   localparam int   SETTLE_CYCLES = BUCKETS + 80;
   localparam int   CYCLE_LIMIT   = 8_000_000;
   localparam int   LONG_HOLD     = 400;

   // Response slice positions inside rsp_tdata
   localparam int CNT_LSB = BUCKET_W;
   localparam int SUM_LSB = BUCKET_W + CNT_W;

   typedef struct packed {
      logic [BUCKET_W-1:0] bucket_us;
      logic [CNT_W-1:0]    sample_count;
      logic [SUM_W-1:0]    ns_sum;
   } hist_result_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_HALF,
      RX_SPARSE,
      RX_MOSTLY
   } rx_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = CMD_RECORD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Shadow copy of the histogram store
   logic [CNT_W-1:0] bucket_tally [BUCKETS];
   logic [CNT_W-1:0] tally_total = '0;
   logic [SUM_W-1:0] ns_total    = '0;

   hist_result_type expected_results [$];
   int              error_count     = 0;
   int              burst_left      = 0;
   int              hold_off_cycles = 0;
   int              rx_left         = 0;
   rx_mode_type     rx_mode         = RX_OPEN;
   int unsigned     cycle_count     = 0;

   latency_histogram_percentile uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one transaction to the shadow store and returns the response it should give.
   function automatic hist_result_type histogram_step(input logic cmd,
                                                      input logic [NS_W-1:0] ns,
                                                      input logic [PPM_W-1:0] ppm);
      hist_result_type  r;
      longint unsigned  us_val;
      longint unsigned  target;
      longint unsigned  running;
      int               b;
      b = 0;
      if (cmd == CMD_RECORD) begin
         // Round up to whole microseconds and clamp into the last bucket.
         us_val = (64'(ns) + 64'(NS_ROUND_UP)) / 64'(NS_PER_US);
         b = (us_val >= 64'(BUCKETS - 1)) ? BUCKETS - 1 : int'(us_val);
         if (bucket_tally[b] != CNT_MAX) begin
            bucket_tally[b] = bucket_tally[b] + 1'b1;
         end
         if (tally_total != CNT_MAX) begin
            tally_total = tally_total + 1'b1;
         end
         ns_total = ns_total + 64'(ns);
      end else if (tally_total != '0) begin
         // Walk the buckets until the running count reaches ceil(count * ppm / 1e6).
         target = (64'(tally_total) * 64'(ppm) + 64'(PPM_ROUND_UP)) / 64'(PPM_SCALE);
         if (target == 0) begin
            target = 1;
         end
         running = 0;
         b = BUCKETS - 1;
         for (int i = 0; i < BUCKETS; i++) begin
            running += 64'(bucket_tally[i]);
            if (running >= target) begin
               b = i;
               break;
            end
         end
      end
      r.bucket_us    = BUCKET_W'(b);
      r.sample_count = tally_total;
      r.ns_sum       = ns_total;
      return r;
   endfunction

   // Offers one request transaction, in bursts with random gaps, and records its outcome.
   task automatic send_request(input logic cmd, input logic [NS_W-1:0] ns,
                               input logic [PPM_W-1:0] ppm);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {(REQ_DATA_W - NS_W - PPM_W)'(0), ppm, ns};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(histogram_step(cmd, ns, ppm));
      burst_left--;
   endtask

   // Stops offering and waits until every outstanding response has been checked.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   function automatic logic [NS_W-1:0] random_latency();
      logic [NS_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1:          v = NS_W'($urandom_range(0, 5000));
         2, 3, 4, 5:    v = NS_W'($urandom_range(0, 1100000));
         6:             v = NS_W'(1000 * $urandom_range(1, 1100) + $urandom_range(0, 2)) - 1'b1;
         default:       v = {8'($urandom), 32'($urandom)};
      endcase
      return v;
   endfunction

   function automatic logic [PPM_W-1:0] random_percentile();
      logic [PPM_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = PPM_W'($urandom);
         1:       v = PPM_W'($urandom_range(990000, 1000000));
         default: v = PPM_W'($urandom_range(0, 1000000));
      endcase
      return v;
   endfunction

   // Queries before anything has been recorded must answer bucket zero.
   task automatic test_empty_histogram();
      send_request(CMD_QUERY, '0, '0);
      send_request(CMD_QUERY, '1, PPM_W'(500000));
      send_request(CMD_QUERY, '0, PPM_W'(1000000));
      send_request(CMD_QUERY, '0, '1);
   endtask

   // Rounding edges, the clamp into the last bucket and the widest latencies.
   task automatic test_latency_extremes();
      send_request(CMD_RECORD, NS_W'(0), PPM_W'($urandom));
      send_request(CMD_RECORD, NS_W'(1), PPM_W'($urandom));
      send_request(CMD_RECORD, NS_W'(999), PPM_W'($urandom));
      send_request(CMD_RECORD, NS_W'(1000), PPM_W'($urandom));
      send_request(CMD_RECORD, NS_W'(1001), '1);
      send_request(CMD_RECORD, NS_W'(2000), '0);
      send_request(CMD_RECORD, NS_W'(1022000), PPM_W'($urandom));
      send_request(CMD_RECORD, NS_W'(1022001), PPM_W'($urandom));
      send_request(CMD_RECORD, NS_W'(1023000), PPM_W'($urandom));
      send_request(CMD_RECORD, NS_W'(1023001), PPM_W'($urandom));
      send_request(CMD_RECORD, {1'b1, (NS_W - 1)'(0)}, PPM_W'($urandom));
      send_request(CMD_RECORD, '1, PPM_W'($urandom));
   endtask

   // Zero target, ordinary percentiles and targets above the sample count.
   task automatic test_query_corners();
      send_request(CMD_QUERY, '0, PPM_W'(0));
      send_request(CMD_QUERY, '1, PPM_W'(1));
      send_request(CMD_QUERY, '0, PPM_W'(499999));
      send_request(CMD_QUERY, '0, PPM_W'(500000));
      send_request(CMD_QUERY, '0, PPM_W'(999999));
      send_request(CMD_QUERY, '0, PPM_W'(1000000));
      send_request(CMD_QUERY, '0, PPM_W'(1000001));
      send_request(CMD_QUERY, '0, '1);
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      wait_for_drain();
      hold_off_cycles = LONG_HOLD;
      repeat (40) send_request(CMD_RECORD, random_latency(), PPM_W'($urandom));
      send_request(CMD_QUERY, '0, random_percentile());
   endtask

   // Mostly records with the odd query, so that queries walk well-filled histograms.
   task automatic test_random_traffic();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(CMD_QUERY, {8'($urandom), 32'($urandom)}, random_percentile());
         end else begin
            send_request(CMD_RECORD, random_latency(), PPM_W'($urandom));
         end
      end
   endtask

   initial begin
      foreach (bucket_tally[i]) bucket_tally[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_histogram();
      test_latency_extremes();
      test_query_corners();
      test_output_backpressure();
      test_random_traffic();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Receiver: a long hold when asked, otherwise stall patterns that change now and then.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 256);
         end
         rx_left = rx_left - 1;
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_HALF:   rsp_tready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
            default:   rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Each response transaction is compared with the oldest outstanding expectation.
   always @(posedge clock) begin : check_responses
      hist_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("response transaction with no request outstanding");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[BUCKET_W-1:0] !== want.bucket_us) begin
               $error("bucket_us: expected %0d, actual %0d",
                      want.bucket_us, rsp_tdata[BUCKET_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[CNT_LSB +: CNT_W] !== want.sample_count) begin
               $error("sample_count: expected %0d, actual %0d",
                      want.sample_count, rsp_tdata[CNT_LSB +: CNT_W]);
               error_count++;
            end
            if (rsp_tdata[SUM_LSB +: SUM_W] !== want.ns_sum) begin
               $error("ns_sum: expected %0d, actual %0d",
                      want.ns_sum, rsp_tdata[SUM_LSB +: SUM_W]);
               error_count++;
            end
         end
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

@@ sim.f @@
rtl/lhp_pkg.sv
rtl/lhp_div.sv
rtl/lhp_datapath.sv
rtl/lhp_ctrl.sv
rtl/latency_histogram_percentile.sv
tb/latency_histogram_percentile_tb.sv
